FILE: src/lsfm_pkg.sv
// lsfm_pkg: shared types and constants for the LED string fault monitor.
// Field widths, register reset values, offset bands and the config register map.
// No dependencies.
package lsfm_pkg;

  // Field widths
  localparam int unsigned RawW    = 12;
  localparam int unsigned MvW     = 12;
  localparam int unsigned DimW    = 10;
  localparam int unsigned BufW    = 13;
  localparam int unsigned ToutW   = 8;
  localparam int unsigned CntW    = 9;
  localparam int unsigned ProdW   = RawW + MvW;
  localparam int unsigned ScaleSh = 12;  // divide by 4096
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 12;

  // Stream payload widths
  localparam int unsigned SDataW = 64;  // 59 bits of fields, zero filled
  localparam int unsigned MDataW = 24;

  // Dimming bands and offsets
  localparam logic [DimW-1:0] DimBand0  = DimW'(10);
  localparam logic [DimW-1:0] DimBand1  = DimW'(20);
  localparam logic [DimW-1:0] DimBand2  = DimW'(80);
  localparam logic [DimW-1:0] DimCutoff = DimW'(4);
  localparam logic [MvW-1:0]  Offset0   = MvW'(50);
  localparam logic [MvW-1:0]  Offset1   = MvW'(30);
  localparam logic [MvW-1:0]  Offset2   = MvW'(20);

  // Register reset values
  localparam logic [MvW-1:0]   WinLowRst   = MvW'(100);
  localparam logic [MvW-1:0]   WinHighRst  = MvW'(3000);
  localparam logic [MvW-1:0]   BufFloorRst = MvW'(2000);
  localparam logic [ToutW-1:0] TimeoutRst  = ToutW'(50);

  // Config register map
  typedef enum logic [CfgIdxW-1:0] {
    REG_WIN_LOW   = 2'd0,
    REG_WIN_HIGH  = 2'd1,
    REG_BUF_FLOOR = 2'd2,
    REG_TIMEOUT   = 2'd3
  } cfg_reg_e;

  // Register file contents as seen by the check logic
  typedef struct packed {
    logic [MvW-1:0]   win_low;
    logic [MvW-1:0]   win_high;
    logic [MvW-1:0]   buf_floor;
    logic [ToutW-1:0] timeout;
  } cfg_t;

  // Per-item check controls handed to the check logic
  typedef struct packed {
    logic            step;    // item moves to the result register
    logic            strobe;  // run window check this item
    logic            buf_ok;  // buffer above floor
    logic            dim_low; // dimming below cutoff, clear counters
  } chk_ctrl_t;

endpackage

FILE: src/lsfm_level.sv
// lsfm_level: scales one raw converter reading to millivolts and removes the
// dimming-dependent offset with a floor at zero. Purely combinational.
// Depends on lsfm_pkg.
module lsfm_level (
  input  logic [lsfm_pkg::RawW-1:0] raw_i,
  input  logic [lsfm_pkg::MvW-1:0]  supply_mv_i,
  input  logic [lsfm_pkg::DimW-1:0] dim_level_i,
  output logic [lsfm_pkg::MvW-1:0]  level_mv_o
);

  logic [lsfm_pkg::ProdW-1:0] prod;
  logic [lsfm_pkg::MvW-1:0]   mv;
  logic [lsfm_pkg::MvW-1:0]   offset;

  // raw * supply / 4096
  assign prod = lsfm_pkg::ProdW'(raw_i) * lsfm_pkg::ProdW'(supply_mv_i);
  assign mv   = prod[lsfm_pkg::ProdW-1:lsfm_pkg::ScaleSh];

  // Offset band from dimming level
  always_comb begin
    if (dim_level_i < lsfm_pkg::DimBand0) begin
      offset = lsfm_pkg::Offset0;
    end else if (dim_level_i < lsfm_pkg::DimBand1) begin
      offset = lsfm_pkg::Offset1;
    end else if (dim_level_i < lsfm_pkg::DimBand2) begin
      offset = lsfm_pkg::Offset2;
    end else begin
      offset = '0;
    end
  end

  // Subtract with floor at zero
  assign level_mv_o = (mv > offset) ? (mv - offset) : '0;

endmodule

FILE: src/lsfm_check.sv
// lsfm_check: window check, persistence counters for both channels and the
// fault latch. State advances only when an item moves to the result register.
// Depends on lsfm_pkg.
module lsfm_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  lsfm_pkg::cfg_t            cfg_i,
  input  lsfm_pkg::chk_ctrl_t       ctrl_i,
  input  logic [lsfm_pkg::MvW-1:0]  level_a_i,
  input  logic [lsfm_pkg::MvW-1:0]  level_b_i,
  output logic                      fault_o    // fault after this item
);

  logic [lsfm_pkg::CntW-1:0] persist_a_q, persist_a_d;
  logic [lsfm_pkg::CntW-1:0] persist_b_q, persist_b_d;
  logic                      fault_q, fault_d;
  logic [lsfm_pkg::CntW-1:0] tout;
  logic                      out_a, out_b;
  logic [lsfm_pkg::CntW-1:0] cnt_a, cnt_b;

  assign tout = lsfm_pkg::CntW'(cfg_i.timeout);

  // Outside-window flags
  assign out_a = (level_a_i < cfg_i.win_low) || (level_a_i > cfg_i.win_high);
  assign out_b = (level_b_i < cfg_i.win_low) || (level_b_i > cfg_i.win_high);

  // Saturating counter step: stops at timeout + 1
  always_comb begin
    cnt_a = '0;
    cnt_b = '0;
    if (out_a && ctrl_i.buf_ok) begin
      cnt_a = (persist_a_q <= tout) ? persist_a_q + 1'b1 : persist_a_q;
    end
    if (out_b && ctrl_i.buf_ok) begin
      cnt_b = (persist_b_q <= tout) ? persist_b_q + 1'b1 : persist_b_q;
    end
  end

  // Strobed update, dimming cutoff clears, then latch test
  always_comb begin
    persist_a_d = persist_a_q;
    persist_b_d = persist_b_q;
    fault_d     = fault_q;
    if (ctrl_i.strobe) begin
      persist_a_d = ctrl_i.dim_low ? '0 : cnt_a;
      persist_b_d = ctrl_i.dim_low ? '0 : cnt_b;
      if ((persist_a_d >= tout) || (persist_b_d >= tout)) begin
        fault_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      persist_a_q <= '0;
      persist_b_q <= '0;
      fault_q     <= 1'b0;
    end else if (ctrl_i.step) begin
      persist_a_q <= persist_a_d;
      persist_b_q <= persist_b_d;
      fault_q     <= fault_d;
    end
  end

  assign fault_o = fault_d;

endmodule

FILE: src/led_string_fault_monitor.sv
// LED string fault monitor top level: stream ports, config registers, input
// register, level scaling and check logic, result register.
// Depends on lsfm_pkg, lsfm_level, lsfm_check.
// Path from input accept to result valid: input register, then result register.
// Throughput: one item per cycle while the result side is not stalled; the input register refills while a result waits.
// Reset: async active low; clears counters, fault latch, valids; config to defaults.
module led_string_fault_monitor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // tdata: raw_a[11:0], raw_b[23:12], supply_mv[35:24], dim_level[45:36],
  //        buffer_mv[58:46], zero [63:59]
  input  logic [lsfm_pkg::SDataW-1:0]  s_axis_tdata,
  // tuser: check_now[0]
  input  logic                         s_axis_tuser,
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // tdata: level_a_mv[11:0], level_b_mv[23:12]
  output logic [lsfm_pkg::MDataW-1:0]  m_axis_tdata,
  // tuser: fault_latched[0]
  output logic                         m_axis_tuser,
  // Config write port
  input  logic                         cfg_we_i,
  input  logic [lsfm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [lsfm_pkg::CfgDatW-1:0] cfg_data_i
);

  lsfm_pkg::cfg_t      cfg_q;
  lsfm_pkg::chk_ctrl_t ctrl;

  logic                       in_valid_q;
  logic [lsfm_pkg::RawW-1:0]  raw_a_q, raw_b_q;
  logic [lsfm_pkg::MvW-1:0]   supply_q;
  logic [lsfm_pkg::DimW-1:0]  dim_q;
  logic [lsfm_pkg::BufW-1:0]  buf_q;
  logic                       check_q;

  logic                       out_valid_q;
  logic [lsfm_pkg::MvW-1:0]   out_lvl_a_q, out_lvl_b_q;
  logic                       out_fault_q;

  logic [lsfm_pkg::MvW-1:0]   lvl_a, lvl_b;
  logic                       fault;
  logic                       step;
  logic                       in_take;

  // Handshake: item moves on when the result register is free or being drained
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.win_low   <= lsfm_pkg::WinLowRst;
      cfg_q.win_high  <= lsfm_pkg::WinHighRst;
      cfg_q.buf_floor <= lsfm_pkg::BufFloorRst;
      cfg_q.timeout   <= lsfm_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      unique case (lsfm_pkg::cfg_reg_e'(cfg_idx_i))
        lsfm_pkg::REG_WIN_LOW:   cfg_q.win_low   <= cfg_data_i;
        lsfm_pkg::REG_WIN_HIGH:  cfg_q.win_high  <= cfg_data_i;
        lsfm_pkg::REG_BUF_FLOOR: cfg_q.buf_floor <= cfg_data_i;
        lsfm_pkg::REG_TIMEOUT:   cfg_q.timeout   <= cfg_data_i[lsfm_pkg::ToutW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      raw_a_q  <= s_axis_tdata[11:0];
      raw_b_q  <= s_axis_tdata[23:12];
      supply_q <= s_axis_tdata[35:24];
      dim_q    <= s_axis_tdata[45:36];
      buf_q    <= s_axis_tdata[58:46];
      check_q  <= s_axis_tuser;
    end
  end

  // Level scaling per channel
  lsfm_level u_level_a (
    .raw_i       (raw_a_q),
    .supply_mv_i (supply_q),
    .dim_level_i (dim_q),
    .level_mv_o  (lvl_a)
  );

  lsfm_level u_level_b (
    .raw_i       (raw_b_q),
    .supply_mv_i (supply_q),
    .dim_level_i (dim_q),
    .level_mv_o  (lvl_b)
  );

  // Check controls
  assign ctrl.step    = step;
  assign ctrl.strobe  = check_q;
  assign ctrl.buf_ok  = buf_q > lsfm_pkg::BufW'(cfg_q.buf_floor);
  assign ctrl.dim_low = dim_q < lsfm_pkg::DimCutoff;

  lsfm_check u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .ctrl_i    (ctrl),
    .level_a_i (lvl_a),
    .level_b_i (lvl_b),
    .fault_o   (fault)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_lvl_a_q <= lvl_a;
      out_lvl_b_q <= lvl_b;
      out_fault_q <= fault;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_lvl_b_q, out_lvl_a_q};
  assign m_axis_tuser  = out_fault_q;

endmodule

FILE: src/lsfm_checker.sv
// lsfm_checker: port-level assertions for the LED string fault monitor, and
// the bind that attaches them to the top level. Depends on lsfm_pkg.
module lsfm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [lsfm_pkg::MDataW-1:0]  m_axis_tdata,
  input logic                         m_axis_tuser
);

  logic [1:0] inflight_q;
  logic       fault_seen_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Items accepted but not yet delivered, and whether a fault was reported
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q   <= '0;
      fault_seen_q <= 1'b0;
    end else begin
      inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
      if (out_acc && m_axis_tuser) begin
        fault_seen_q <= 1'b1;
      end
    end
  end

  // The fault, once reported, is reported on every later item
  a_fault_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && fault_seen_q) |-> m_axis_tuser)
    else $error("fault flag dropped after being reported");

  // No result without an accepted item, and at most two items held
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (inflight_q != 2'd0))
    else $error("result without accepted item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q != 2'd3)
    else $error("more items held than stages");

  // An empty result side never stalls the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  // A stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");

endmodule

bind led_string_fault_monitor lsfm_checker u_lsfm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: dv/led_string_fault_monitor_test.sv
// Self-checking testbench for led_string_fault_monitor: stream driver, result
// monitor and a cycle-free predictor of levels, persistence counters and latch.
// Depends on lsfm_pkg and the led_string_fault_monitor RTL.
module led_string_fault_monitor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // One input item and one result item
  typedef struct packed {
    logic [lsfm_pkg::BufW-1:0] buffer_mv;
    logic [lsfm_pkg::DimW-1:0] dim;
    logic [lsfm_pkg::MvW-1:0]  supply;
    logic [lsfm_pkg::RawW-1:0] raw_b;
    logic [lsfm_pkg::RawW-1:0] raw_a;
    logic                      check;
  } sample_t;

  typedef struct packed {
    logic                     fault;
    logic [lsfm_pkg::MvW-1:0] level_a;
    logic [lsfm_pkg::MvW-1:0] level_b;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [lsfm_pkg::SDataW-1:0]  s_axis_tdata = '0;
  logic                         s_axis_tuser = 1'b0;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [lsfm_pkg::MDataW-1:0]  m_axis_tdata;
  logic                         m_axis_tuser;
  logic                         cfg_we_i = 1'b0;
  logic [lsfm_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [lsfm_pkg::CfgDatW-1:0] cfg_data_i = '0;

  led_string_fault_monitor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow of the register file and of the monitor state
  logic [lsfm_pkg::MvW-1:0]   win_low_q   = 12'd100;
  logic [lsfm_pkg::MvW-1:0]   win_high_q  = 12'd3000;
  logic [lsfm_pkg::MvW-1:0]   floor_q     = 12'd2000;
  logic [lsfm_pkg::ToutW-1:0] timeout_q   = 8'd50;
  logic [lsfm_pkg::CntW-1:0]  persist_a_q = '0;
  logic [lsfm_pkg::CntW-1:0]  persist_b_q = '0;
  logic                       fault_q     = 1'b0;

  sample_t pending_samples[$];
  report_t due_reports[$];
  sample_t on_bus;

  int n_accepted  = 0;
  int n_reports   = 0;
  int n_errors    = 0;
  int n_settings  = 1;

  // Supply-scaled reading minus the dimming offset, floored at zero
  function automatic logic [lsfm_pkg::MvW-1:0] corrected_mv(
      logic [lsfm_pkg::RawW-1:0] raw,
      logic [lsfm_pkg::MvW-1:0]  supply,
      logic [lsfm_pkg::DimW-1:0] dim);
    logic [lsfm_pkg::ProdW-1:0] prod;
    logic [lsfm_pkg::MvW-1:0]   mv;
    logic [lsfm_pkg::MvW-1:0]   off;
    prod = lsfm_pkg::ProdW'(raw) * lsfm_pkg::ProdW'(supply);
    mv   = prod[lsfm_pkg::ProdW-1:12];
    if (dim < 10'd10)      off = 12'd50;
    else if (dim < 10'd20) off = 12'd30;
    else if (dim < 10'd80) off = 12'd20;
    else                   off = 12'd0;
    return (mv > off) ? mv - off : '0;
  endfunction

  // Counter grows while the level is out of window and the buffer is healthy
  function automatic logic [lsfm_pkg::CntW-1:0] next_persist(
      logic [lsfm_pkg::CntW-1:0] cnt,
      logic [lsfm_pkg::MvW-1:0]  lvl,
      logic                      buf_ok);
    if ((lvl < win_low_q || lvl > win_high_q) && buf_ok)
      return (cnt <= {1'b0, timeout_q}) ? cnt + 1'b1 : cnt;
    return '0;
  endfunction

  // Advance the shadow state by one item and return the report it causes
  function automatic report_t compute_report(sample_t s);
    report_t r;
    logic    buf_ok;
    r.level_a = corrected_mv(s.raw_a, s.supply, s.dim);
    r.level_b = corrected_mv(s.raw_b, s.supply, s.dim);
    if (s.check) begin
      buf_ok = s.buffer_mv > {1'b0, floor_q};
      persist_a_q = next_persist(persist_a_q, r.level_a, buf_ok);
      persist_b_q = next_persist(persist_b_q, r.level_b, buf_ok);
      if (s.dim < 10'd4) begin
        persist_a_q = '0;
        persist_b_q = '0;
      end
      if (persist_a_q >= {1'b0, timeout_q} || persist_b_q >= {1'b0, timeout_q})
        fault_q = 1'b1;
    end
    r.fault = fault_q;
    return r;
  endfunction

  // Driver: bursts of items with random gaps, prediction at acceptance
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        due_reports.push_back(compute_report(on_bus));
        n_accepted++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          on_bus = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {5'b0, on_bus.buffer_mv, on_bus.dim, on_bus.supply,
                            on_bus.raw_b, on_bus.raw_a};
          s_axis_tuser  <= on_bus.check;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern chosen by the upper bits of a free-running counter, plus one long hold-off
  logic [8:0] rx_cycle   = '0;
  int         hold_left  = 0;
  logic       hold_done  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1'b1;
      if (hold_left > 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && n_reports >= 200) begin
        hold_done     <= 1'b1;
        hold_left     <= 60;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_cycle[8:6])
          3'd0, 3'd1: m_axis_tready <= 1'b1;
          3'd2, 3'd3: m_axis_tready <= 1'($urandom_range(0, 1));
          3'd4:       m_axis_tready <= (rx_cycle[1:0] != 2'd0);
          3'd5:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          3'd6:       m_axis_tready <= rx_cycle[2];
          default:    m_axis_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Monitor: compare each result with the oldest due report
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      n_reports <= n_reports + 1;
      if (due_reports.size() == 0) begin
        $display("%0t: unexpected result: fault=%0b level_a=%0d level_b=%0d", $time,
                 m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12]);
        n_errors++;
      end else begin
        want = due_reports.pop_front();
        if (m_axis_tuser !== want.fault) begin
          $display("%0t: fault_latched expected %0b actual %0b", $time, want.fault,
                   m_axis_tuser);
          n_errors++;
        end
        if (m_axis_tdata[11:0] !== want.level_a) begin
          $display("%0t: level_a_mv expected %0d actual %0d", $time, want.level_a,
                   m_axis_tdata[11:0]);
          n_errors++;
        end
        if (m_axis_tdata[23:12] !== want.level_b) begin
          $display("%0t: level_b_mv expected %0d actual %0d", $time, want.level_b,
                   m_axis_tdata[23:12]);
          n_errors++;
        end
      end
    end
  end

  // Stimulus helpers
  function automatic sample_t mk(int ra, int rb, int sup, int dim, int bmv, bit chk);
    sample_t s;
    s.raw_a     = lsfm_pkg::RawW'(ra);
    s.raw_b     = lsfm_pkg::RawW'(rb);
    s.supply    = lsfm_pkg::MvW'(sup);
    s.dim       = lsfm_pkg::DimW'(dim);
    s.buffer_mv = lsfm_pkg::BufW'(bmv);
    s.check     = chk;
    return s;
  endfunction

  function automatic int pick12();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 4095;
      default: return $urandom_range(0, 4095);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    int      b;
    s.raw_a  = lsfm_pkg::RawW'(pick12());
    s.raw_b  = lsfm_pkg::RawW'(pick12());
    s.supply = lsfm_pkg::MvW'(pick12());
    case ($urandom_range(0, 5))
      0:       s.dim = lsfm_pkg::DimW'($urandom_range(0, 3));
      1:       s.dim = lsfm_pkg::DimW'($urandom_range(4, 9));
      2:       s.dim = lsfm_pkg::DimW'($urandom_range(10, 19));
      3:       s.dim = lsfm_pkg::DimW'($urandom_range(20, 79));
      4:       s.dim = lsfm_pkg::DimW'($urandom_range(80, 1023));
      default: s.dim = lsfm_pkg::DimW'($urandom_range(0, 1023));
    endcase
    // buffer: full range, or right at the floor
    if ($urandom_range(0, 3) == 0) begin
      b = int'(floor_q) + $urandom_range(0, 4) - 2;
      s.buffer_mv = (b < 0) ? '0 : lsfm_pkg::BufW'(b);
    end else begin
      s.buffer_mv = lsfm_pkg::BufW'($urandom_range(0, 8191));
    end
    s.check = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Strobed item with the buffer healthy and chosen channels driven to a rail, out of window unless the window spans it
  function automatic sample_t failing_sample(int chan);
    sample_t s;
    logic    hi_side;
    s = rand_sample();
    s.check     = 1'b1;
    s.dim       = lsfm_pkg::DimW'($urandom_range(4, 1023));
    s.buffer_mv = lsfm_pkg::BufW'($urandom_range(int'(floor_q) + 1, 8191));
    hi_side = (win_low_q == '0) ||
              (win_high_q < 12'd4044 && $urandom_range(0, 1) != 0);
    if (hi_side) s.supply = 12'd4095;
    if (chan != 1) s.raw_a = hi_side ? 12'd4095 : 12'd0;
    if (chan != 0) s.raw_b = hi_side ? 12'd4095 : 12'd0;
    return s;
  endfunction

  // Strobe below the dimming cutoff: clears both counters
  function automatic sample_t clearing_sample();
    sample_t s;
    s = rand_sample();
    s.check = 1'b1;
    s.dim   = lsfm_pkg::DimW'($urandom_range(0, 3));
    return s;
  endfunction

  function automatic sample_t quiet_sample();
    sample_t s;
    s = rand_sample();
    s.check = 1'b0;
    return s;
  endfunction

  task automatic write_reg(lsfm_pkg::cfg_reg_e idx, logic [lsfm_pkg::CfgDatW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      lsfm_pkg::REG_WIN_LOW:   win_low_q  = val;
      lsfm_pkg::REG_WIN_HIGH:  win_high_q = val;
      lsfm_pkg::REG_BUF_FLOOR: floor_q    = val;
      lsfm_pkg::REG_TIMEOUT:   timeout_q  = val[lsfm_pkg::ToutW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(int lo, int hi, int fl, int tout);
    write_reg(lsfm_pkg::REG_WIN_LOW, lsfm_pkg::CfgDatW'(lo));
    write_reg(lsfm_pkg::REG_WIN_HIGH, lsfm_pkg::CfgDatW'(hi));
    write_reg(lsfm_pkg::REG_BUF_FLOOR, lsfm_pkg::CfgDatW'(fl));
    write_reg(lsfm_pkg::REG_TIMEOUT, lsfm_pkg::CfgDatW'(tout));
    n_settings++;
  endtask

  // Wait until every item is out and every report has come back
  task automatic drain();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || due_reports.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Runs of failing strobes shorter than the timeout, each closed by a clear,
  // mixed with short noise bursts; the latch must stay open throughout.
  task automatic random_phase(int n_items);
    int left;
    int run_max;
    int k;
    left    = n_items;
    run_max = (int'(timeout_q) - 2 > 40) ? 40 : int'(timeout_q) - 2;
    while (left > 0) begin
      if ($urandom_range(0, 3) == 0) begin
        k = $urandom_range(1, 3);
        repeat (k) pending_samples.push_back(rand_sample());
      end else begin
        k = $urandom_range(1, run_max);
        repeat (k) begin
          case ($urandom_range(0, 9))
            7, 8:    pending_samples.push_back(quiet_sample());
            9:       pending_samples.push_back(rand_sample());
            default: pending_samples.push_back(failing_sample($urandom_range(0, 2)));
          endcase
        end
      end
      pending_samples.push_back(clearing_sample());
      left -= k + 1;
    end
  endtask

  // Counter runs stopping one short of the timeout, then one that reaches it
  task automatic counter_run(int len);
    repeat (len) begin
      pending_samples.push_back(failing_sample($urandom_range(0, 2)));
      if ($urandom_range(0, 2) == 0) pending_samples.push_back(quiet_sample());
    end
  endtask

  initial begin
    int lo;
    int hi;
    int fl;
    int tout;
    int zero_path;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset settings
    pending_samples.push_back(mk(0, 0, 0, 0, 0, 0));
    pending_samples.push_back(mk(4095, 4095, 4095, 1023, 8191, 0));
    pending_samples.push_back(mk(4095, 4095, 4095, 1023, 8191, 1));
    pending_samples.push_back(mk(4095, 0, 4095, 1023, 8191, 0));  // no strobe: hold
    pending_samples.push_back(mk(4095, 0, 4095, 3, 8191, 1));     // below cutoff
    pending_samples.push_back(mk(4095, 4095, 4095, 4, 8191, 1));  // at cutoff
    pending_samples.push_back(mk(4095, 4095, 4095, 100, 2000, 1)); // buffer at floor
    pending_samples.push_back(mk(4095, 4095, 4095, 100, 2001, 1));
    pending_samples.push_back(mk(4095, 4095, 4095, 100, 4196, 1)); // bit 12 of buffer
    pending_samples.push_back(mk(100, 100, 2048, 9, 8191, 0));     // offset band edges
    pending_samples.push_back(mk(100, 100, 2048, 10, 8191, 0));
    pending_samples.push_back(mk(100, 100, 2048, 19, 8191, 0));
    pending_samples.push_back(mk(100, 100, 2048, 20, 8191, 0));
    pending_samples.push_back(mk(100, 100, 2048, 79, 8191, 0));
    pending_samples.push_back(mk(100, 100, 2048, 80, 8191, 0));
    pending_samples.push_back(mk(200, 198, 2048, 1023, 8191, 1));  // 100 in, 99 out
    pending_samples.push_back(mk(4000, 4002, 3072, 1023, 8191, 1)); // 3000 in, 3001 out
    pending_samples.push_back(mk(2048, 0, 2000, 500, 8191, 1));
    pending_samples.push_back(mk(4095, 4095, 0, 1023, 8191, 1));   // zero supply
    pending_samples.push_back(mk(0, 0, 0, 2, 0, 1));
    random_phase(100);
    drain();

    // Random phases over several settings, extremes first
    for (int p = 1; p <= 6; p++) begin
      lo   = $urandom_range(0, 1500);
      hi   = $urandom_range(lo, 4095);
      fl   = $urandom_range(0, 4095);
      tout = $urandom_range(20, 254);
      case (p)
        1: begin lo = 0; hi = 4095; tout = 255; end
        2: begin lo = 4095; fl = 0; end
        3: begin hi = 0; tout = 255; end
        4: fl = 4095;
        default: ;
      endcase
      set_config(lo, hi, fl, tout);
      random_phase(110);
      drain();
    end

    // Closing phase: the fault latches, either by counting or by a zero timeout
    zero_path = $urandom_range(0, 1);
    if (zero_path) begin
      set_config($urandom_range(0, 4095), $urandom_range(0, 4095),
                 $urandom_range(0, 4095), 0);
      repeat (20) pending_samples.push_back(quiet_sample());
      pending_samples.push_back(clearing_sample());  // latches with counters cleared
    end else begin
      tout = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
      set_config(200, 3000, $urandom_range(0, 3000), tout);
      repeat (3) begin
        pending_samples.push_back(clearing_sample());
        counter_run(tout - 1);
      end
      pending_samples.push_back(clearing_sample());
      counter_run(tout);
    end
    repeat (40) pending_samples.push_back(rand_sample());
    drain();

    $display("Checked %0d results from %0d items over %0d register settings.",
             n_reports, n_accepted, n_settings);
    if (zero_path)
      $display("Fault latch closed out by a zero timeout on a cleared strobe.");
    else
      $display("Fault latch closed out by a counter reaching timeout %0d.", tout);
    if (n_errors == 0)
      $display("** led_string_fault_monitor: PASSED **");
    else
      $display("** led_string_fault_monitor: FAILED **");
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("Timed out with %0d items pending and %0d results due.",
             pending_samples.size(), due_reports.size());
    $display("** led_string_fault_monitor: FAILED **");
    $finish;
  end

endmodule

FILE: led_string_fault_monitor.f
src/lsfm_pkg.sv
src/lsfm_level.sv
src/lsfm_check.sv
src/led_string_fault_monitor.sv
src/lsfm_checker.sv
dv/led_string_fault_monitor_test.sv
